@@ sv/gnss_binary_and_sentence_framer_top_assert.svh @@
// ---------------------------------------------------------------------------
// GNSS framer assertion macros
// Immediate-cycle and next-cycle implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GNSS_BINARY_AND_SENTENCE_FRAMER_TOP_ASSERT_SVH
`define GNSS_BINARY_AND_SENTENCE_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define GNSSF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GNSSF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GNSSF_ASSERT(lbl, ante, cons, msg)
`define GNSSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/gnssf_pkg.sv @@
// ---------------------------------------------------------------------------
// GNSS framer package
// Shared event codes, result record and defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package gnssf_pkg;

	localparam int BUF_LEN_DEF = 1024;

	localparam int OUT_TDATA_W = 64;
	localparam int OUT_TUSER_W = 3;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_BIN   = 3'd1,
		EV_GP    = 3'd2,
		EV_PUBX  = 3'd3,
		EV_RESET = 3'd4
	} event_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        byte_kept;
		logic [9:0]  byte_pos;
		event_t      event_res;
		logic [15:0] class_and_id;
		logic [15:0] payload_length;
		logic [10:0] frame_length;
	} res_t;

endpackage

`default_nettype wire

@@ sv/gnss_binary_and_sentence_framer_top.sv @@
// ---------------------------------------------------------------------------
// GNSS binary and sentence framer
// Frames binary sync messages and "$GP"/"$PUBX" text sentences byte by byte.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per request in tdata[7:0].
//   m_axis returns one result request per input byte: the echoed byte, a
//   kept flag and frame position in tdata, the frame event in tuser.
//   Binary frame completion carries class/id, payload length and total
//   frame length; sentence completion carries the frame length.
// Path: an accepted byte is held in the input register; its result is
//   loaded into the result register and offered on m_axis when the output is free.
// Throughput: one byte per cycle while m_axis_tready is high, set by the state
//   update in the parser between the input register and the result register.
// Reset: arst_n clears the valid flags of both pipeline registers and the parser to idle.
// Stall: while m_axis_tready is low the result holds, at most one more byte is
//   taken into the input register, then s_axis_tready drops until the
//   result is taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gnss_binary_and_sentence_framer_top_assert.svh"

module gnss_binary_and_sentence_framer_top import gnssf_pkg::*; #(
	parameter int BUF_LEN = BUF_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // rx_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] byte_out, [8] byte_kept,
	                                              // [18:9] byte_pos, [34:19] class_and_id,
	                                              // [50:35] payload_length,
	                                              // [61:51] frame_length
	output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [2:0] event_res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       out_free;
	res_t       res;

	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	gnssf_parser #(
		.BUF_LEN (BUF_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.res     (res)
	);

	gnssf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.d        (res),
		.can_load (out_free),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tuser    (m_axis_tuser)
	);

	`GNSSF_ASSERT(a_err_drops, adv && res.event_res == EV_RESET, !res.byte_kept, "error byte kept")
	`GNSSF_ASSERT(a_ids_bin_only, adv && res.event_res != EV_BIN, res.class_and_id == 16'h0000 && res.payload_length == 16'h0000, "ids outside binary completion")
	`GNSSF_ASSERT_NXT(a_load_valid, adv, m_axis_tvalid, "result lost after load")
	`GNSSF_ASSERT(a_accept_free, valid_s1 && !m_axis_tvalid, s_axis_tready, "input stalled with free output")

endmodule

`default_nettype wire

@@ sv/gnssf_parser.sv @@
// ---------------------------------------------------------------------------
// GNSS framer parser
// Frame state machine: decodes one byte per step, updates frame state.
// ---------------------------------------------------------------------------
`default_nettype none

module gnssf_parser import gnssf_pkg::*; #(
	parameter int BUF_LEN = BUF_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	localparam int CW    = $clog2(BUF_LEN + 1);
	localparam int CMP_W = (CW + 1 > 17) ? CW + 1 : 17;
	localparam logic [CW-1:0]    CNT_LIM = CW'(BUF_LEN);
	localparam logic [CMP_W-1:0] HDR_LEN = CMP_W'(6);

	localparam logic [7:0] CH_SYNC1  = 8'hB5;
	localparam logic [7:0] CH_SYNC2  = 8'h62;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN1, ST_PAYLOAD, ST_CKA,
		ST_CKB, ST_DOLLAR, ST_G, ST_P, ST_PU, ST_PUB, ST_BODY, ST_CR
	} state_t;

	typedef enum logic [1:0] {
		KIND_NONE, KIND_GP, KIND_PUBX
	} kind_t;

	state_t           state_q, state_n;
	kind_t            kind_q, kind_n;
	logic [15:0]      cid_q, cid_n;
	logic [15:0]      len_q, len_n;
	logic [CW-1:0]    cnt_q;
	logic [CMP_W-1:0] cnt_p1;
	logic             kept, err, room, is_class;
	event_t           ev;

	always_comb begin
		case (rx_byte) inside
			8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h0A, 8'h0B, 8'h0D, 8'h10: is_class = 1'b1;
			default: is_class = 1'b0;
		endcase
	end

	assign room   = cnt_q < CNT_LIM;
	assign cnt_p1 = CMP_W'(cnt_q) + CMP_W'(1);

	always_comb begin
		state_n = state_q;
		kind_n  = kind_q;
		cid_n   = cid_q;
		len_n   = len_q;
		kept    = 1'b0;
		err     = 1'b0;
		ev      = EV_NONE;
		res.class_and_id   = '0;
		res.payload_length = '0;
		res.frame_length   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (rx_byte == CH_SYNC1) begin
					kept = 1'b1; state_n = ST_SYNC1;
				end else if (rx_byte == CH_DOLLAR) begin
					kept = 1'b1; state_n = ST_DOLLAR;
				end
			end
			ST_SYNC1: begin
				if (rx_byte == CH_SYNC2) begin
					kept = 1'b1; state_n = ST_SYNC2;
				end else err = 1'b1;
			end
			ST_SYNC2: begin
				if (is_class) begin
					kept = 1'b1; cid_n = {rx_byte, 8'h00}; state_n = ST_CLASS;
				end else err = 1'b1;
			end
			ST_CLASS: begin
				kept = 1'b1; cid_n = {cid_q[15:8], rx_byte}; state_n = ST_ID;
			end
			ST_ID: begin
				kept = 1'b1; len_n = {8'h00, rx_byte}; state_n = ST_LEN1;
			end
			ST_LEN1: begin
				kept    = 1'b1;
				len_n   = {rx_byte, len_q[7:0]};
				state_n = (len_n == 16'h0000) ? ST_CKA : ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (room) begin
					kept = 1'b1;
					if (cnt_p1 >= CMP_W'(len_q) + HDR_LEN) state_n = ST_CKA;
				end else err = 1'b1;
			end
			ST_CKA: begin
				if (room) begin
					kept = 1'b1; state_n = ST_CKB;
				end else err = 1'b1;
			end
			ST_CKB: begin
				if (room) begin
					kept = 1'b1;
					ev   = EV_BIN;
					res.class_and_id   = cid_q;
					res.payload_length = len_q;
					res.frame_length   = cnt_p1[10:0];
				end else err = 1'b1;
			end
			ST_DOLLAR: begin
				if (rx_byte == CH_G) begin
					kept = 1'b1; state_n = ST_G;
				end else if (rx_byte == CH_P) begin
					kept = 1'b1; state_n = ST_P;
				end else err = 1'b1;
			end
			ST_G: begin
				if (rx_byte == CH_P) begin
					kept = 1'b1; kind_n = KIND_GP; state_n = ST_BODY;
				end else err = 1'b1;
			end
			ST_P: begin
				if (rx_byte == CH_U) begin
					kept = 1'b1; state_n = ST_PU;
				end else err = 1'b1;
			end
			ST_PU: begin
				if (rx_byte == CH_B) begin
					kept = 1'b1; state_n = ST_PUB;
				end else err = 1'b1;
			end
			ST_PUB: begin
				if (rx_byte == CH_X) begin
					kept = 1'b1; kind_n = KIND_PUBX; state_n = ST_BODY;
				end else err = 1'b1;
			end
			ST_BODY: begin
				if (room) begin
					kept = 1'b1;
					if (rx_byte == CH_CR) state_n = ST_CR;
				end else err = 1'b1;
			end
			ST_CR: begin
				if (room) begin
					kept = 1'b1;
					if (rx_byte == CH_LF) begin
						ev = (kind_q == KIND_PUBX) ? EV_PUBX : EV_GP;
						res.frame_length = cnt_p1[10:0];
					end
				end else err = 1'b1;
			end
		endcase
		if (err) ev = EV_RESET;
		res.byte_out  = rx_byte;
		res.byte_kept = kept;
		res.byte_pos  = kept ? 10'(cnt_q) : 10'd0;
		res.event_res = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_NONE;
			cid_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			if (ev != EV_NONE) begin
				state_q <= ST_IDLE;
				kind_q  <= KIND_NONE;
				cid_q   <= '0;
				len_q   <= '0;
				cnt_q   <= '0;
			end else begin
				state_q <= state_n;
				kind_q  <= kind_n;
				cid_q   <= cid_n;
				len_q   <= len_n;
				if (kept) cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/gnssf_out_reg.sv @@
// ---------------------------------------------------------------------------
// GNSS framer result register
// Holds one result request and packs it onto the output stream.
// ---------------------------------------------------------------------------
`default_nettype none

module gnssf_out_reg import gnssf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_t                   d,
	output logic                   can_load,
	output logic                   tvalid,
	input  logic                   tready,
	output logic [OUT_TDATA_W-1:0] tdata,  // byte_out, byte_kept, byte_pos, class_and_id,
	                                       // payload_length, frame_length, zero fill
	output logic [OUT_TUSER_W-1:0] tuser   // event_res
);

	res_t res_s2;
	logic valid_s2;

	assign can_load = !valid_s2 || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) res_s2 <= d;
	end

	assign tvalid = valid_s2;
	assign tdata  = {2'b00, res_s2.frame_length, res_s2.payload_length, res_s2.class_and_id,
		res_s2.byte_pos, res_s2.byte_kept, res_s2.byte_out};
	assign tuser  = res_s2.event_res;

endmodule

`default_nettype wire
